// ===== rtl/core/sib_pkg.sv =====
// shared types, constants and helpers of the scaled index image blitter
`default_nettype none

package sib_pkg;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;

  // canvas sizes above this saturate for clipping and for the row stride
  localparam logic [10:0] CANVAS_MAX = 11'd1024;
  // scale factors above this saturate
  localparam logic [3:0]  MAX_SCALE  = 4'd8;

  typedef enum logic {
    OP_BLIT = 1'b0,
    OP_LOAD = 1'b1
  } sib_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_CLIP_LEFT     = 3'd2,
    CFG_CLIP_TOP      = 3'd3,
    CFG_CLIP_RIGHT    = 3'd4,
    CFG_CLIP_BOTTOM   = 3'd5,
    CFG_CANVAS_WIDTH  = 3'd6,
    CFG_CANVAS_HEIGHT = 3'd7
  } sib_cfg_idx_t;

  typedef struct packed {
    logic signed [12:0] origin_x;
    logic signed [12:0] origin_y;
    logic [10:0]        clip_left;
    logic [10:0]        clip_top;
    logic [10:0]        clip_right;
    logic [10:0]        clip_bottom;
    logic [10:0]        canvas_width;
    logic [10:0]        canvas_height;
  } sib_cfg_t;

  // inclusive rectangle of writes that survive clipping, plus the color
  typedef struct packed {
    logic [9:0] x_lo;
    logic [9:0] x_hi;
    logic [9:0] y_lo;
    logic [9:0] y_hi;
    logic [7:0] color;
  } sib_span_t;

  function automatic logic [10:0] sat_canvas(input logic [10:0] v);
    return (v > CANVAS_MAX) ? CANVAS_MAX : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sib_if.sv =====
// valid/ready channel interfaces for source pixels and framebuffer writes
`default_nettype none

interface sib_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [7:0]        src_col;
  logic [7:0]        src_row;
  logic signed [7:0] pixel_index;
  logic [8:0]        image_width;
  logic [8:0]        image_height;
  logic [1:0]        flip_mode;
  logic [3:0]        scale_factor;
  logic signed [7:0] key_index;
  logic [7:0]        map_color;
  logic              hide_flag;

  modport source (
    output valid, operation, src_col, src_row, pixel_index, image_width,
           image_height, flip_mode, scale_factor, key_index, map_color, hide_flag,
    input  ready
  );

  modport sink (
    input  valid, operation, src_col, src_row, pixel_index, image_width,
           image_height, flip_mode, scale_factor, key_index, map_color, hide_flag,
    output ready
  );
endinterface

interface sib_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic [19:0] write_address;
  logic [7:0]  color;
  logic        last_write;

  modport source (
    output valid, pixel_x, pixel_y, write_address, color, last_write,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, write_address, color, last_write,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/sib_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module sib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sib_palette.sv =====
// palette map and hidden flags: ram plus per entry valid bits for reset values
`default_nettype none

module sib_palette #(
  parameter int ENTRIES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire logic       rd_en,
  input  wire logic [7:0] index,
  input  wire logic [7:0] wr_color,
  input  wire logic       wr_hide,
  output      logic [7:0] rd_color,
  output      logic       rd_hide
);

  localparam int  EW   = $clog2(ENTRIES);
  localparam bit  POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

  logic [EW-1:0]      entry;
  logic [ENTRIES-1:0] vld_r;
  logic               rd_vld_r;
  logic [EW-1:0]      rd_entry_r;
  logic [8:0]         rd_q;

  generate
    if (POW2) begin : g_mask
      assign entry = index[EW-1:0];
    end else begin : g_recip
      // index mod ENTRIES via reciprocal; exact for 8 bit indexes when ENTRIES is 9 or more
      localparam int RECIP = (65536 + ENTRIES - 1) / ENTRIES;
      logic [20:0] prod;
      logic [12:0] quo_n;
      logic [12:0] rem;
      assign prod  = 21'(index) * 21'(RECIP);
      assign quo_n = 13'(prod[20:16]) * 13'(ENTRIES);
      assign rem   = 13'(index) - quo_n;
      assign entry = rem[EW-1:0];
    end
  endgenerate

  sib_ram #(
    .WIDTH (9),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (entry),
    .wdata ({wr_hide, wr_color}),
    .re    (rd_en),
    .raddr (entry),
    .rdata (rd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[entry] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r   <= vld_r[entry];
      rd_entry_r <= entry;
    end
  end

  // never written entries read as identity color, not hidden
  assign rd_color = rd_vld_r ? rd_q[7:0] : 8'(rd_entry_r);
  assign rd_hide  = rd_vld_r & rd_q[8];

endmodule

`default_nettype wire

// ===== rtl/core/sib_geom.sv =====
// front pipeline: palette lookup, drop tests, flip, scale and clip to a span
`default_nettype none

module sib_geom #(
  parameter int ENTRIES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sib_pkg::sib_cfg_t  cfg,
  sib_in_if.sink                  in_ch,
  output      logic               span_valid,
  input  wire logic               span_ready,
  output      sib_pkg::sib_span_t span
);

  import sib_pkg::*;

  // stage 1: accepted blit and palette read
  logic              v1_r;
  logic [7:0]        col1_r, row1_r;
  logic signed [7:0] pix1_r, key1_r;
  logic [8:0]        iw1_r, ih1_r;
  logic [1:0]        flip1_r;
  logic [3:0]        scale1_r;
  logic [7:0]        pal_color;
  logic              pal_hide;

  // stage 2: destination cell and clamped scale
  logic              v2_r;
  logic [8:0]        dx2_r, dy2_r;
  logic [3:0]        scl2_r;
  logic [7:0]        color2_r;

  // stage 3: cell extent on the canvas
  logic              v3_r;
  logic signed [15:0] bx3_r, ex3_r, by3_r, ey3_r;
  logic [7:0]        color3_r;

  logic r1, r2, s3_go;
  logic acc, acc_blit, acc_load;

  logic       in_img, keep;
  logic [8:0] dx1, dy1;
  logic [3:0] scl1;

  logic [12:0]        mx2, my2;
  logic signed [15:0] bx2, ex2, by2, ey2;

  logic [10:0]        xlim, ylim, cw, ch;
  logic signed [15:0] xlast, ylast, clip_l, clip_t;
  logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
  logic               nonempty;

  assign acc      = in_ch.valid & r1;
  assign acc_blit = acc & (in_ch.operation == OP_BLIT);
  assign acc_load = acc & (in_ch.operation == OP_LOAD);

  assign s3_go = !v3_r | !nonempty | span_ready;
  assign r2    = !v2_r | s3_go;
  assign r1    = !v1_r | r2;
  assign in_ch.ready = r1;

  sib_palette #(
    .ENTRIES (ENTRIES)
  ) u_palette (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (acc_load),
    .rd_en    (acc_blit),
    .index    (in_ch.pixel_index),
    .wr_color (in_ch.map_color),
    .wr_hide  (in_ch.hide_flag),
    .rd_color (pal_color),
    .rd_hide  (pal_hide)
  );

  // stage 1 -> 2
  always_comb begin
    in_img = ({1'b0, col1_r} < iw1_r) && ({1'b0, row1_r} < ih1_r);
    keep   = in_img && (pix1_r != key1_r) && !pix1_r[7] && !pal_hide;
    dx1    = flip1_r[0] ? (iw1_r - 9'd1 - {1'b0, col1_r}) : {1'b0, col1_r};
    dy1    = flip1_r[1] ? (ih1_r - 9'd1 - {1'b0, row1_r}) : {1'b0, row1_r};
    if (scale1_r == 4'd0) begin
      scl1 = 4'd1;
    end else if (scale1_r > MAX_SCALE) begin
      scl1 = MAX_SCALE;
    end else begin
      scl1 = scale1_r;
    end
  end

  // stage 2 -> 3
  always_comb begin
    mx2 = 13'(dx2_r) * 13'(scl2_r);
    my2 = 13'(dy2_r) * 13'(scl2_r);
    bx2 = 16'($signed(cfg.origin_x)) + $signed({3'b000, mx2});
    by2 = 16'($signed(cfg.origin_y)) + $signed({3'b000, my2});
    ex2 = bx2 + $signed({12'd0, scl2_r}) - 16'sd1;
    ey2 = by2 + $signed({12'd0, scl2_r}) - 16'sd1;
  end

  // stage 3: intersect the cell with clip rectangle and canvas
  always_comb begin
    cw     = sat_canvas(cfg.canvas_width);
    ch     = sat_canvas(cfg.canvas_height);
    xlim   = (cfg.clip_right < cw) ? cfg.clip_right : cw;
    ylim   = (cfg.clip_bottom < ch) ? cfg.clip_bottom : ch;
    xlast  = $signed({5'd0, xlim}) - 16'sd1;
    ylast  = $signed({5'd0, ylim}) - 16'sd1;
    clip_l = $signed({5'd0, cfg.clip_left});
    clip_t = $signed({5'd0, cfg.clip_top});
    lo_x   = (bx3_r < clip_l) ? clip_l : bx3_r;
    lo_y   = (by3_r < clip_t) ? clip_t : by3_r;
    hi_x   = (ex3_r < xlast) ? ex3_r : xlast;
    hi_y   = (ey3_r < ylast) ? ey3_r : ylast;
    nonempty = (lo_x <= hi_x) && (lo_y <= hi_y);
  end

  assign span_valid = v3_r & nonempty;
  assign span.x_lo  = lo_x[9:0];
  assign span.x_hi  = hi_x[9:0];
  assign span.y_lo  = lo_y[9:0];
  assign span.y_hi  = hi_y[9:0];
  assign span.color = color3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (r1) begin
        v1_r <= acc_blit;
      end
      if (r2) begin
        v2_r <= v1_r & keep;
      end
      if (s3_go) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_blit) begin
      col1_r   <= in_ch.src_col;
      row1_r   <= in_ch.src_row;
      pix1_r   <= in_ch.pixel_index;
      key1_r   <= in_ch.key_index;
      iw1_r    <= in_ch.image_width;
      ih1_r    <= in_ch.image_height;
      flip1_r  <= in_ch.flip_mode;
      scale1_r <= in_ch.scale_factor;
    end
    if (r2 && v1_r) begin
      dx2_r    <= dx1;
      dy2_r    <= dy1;
      scl2_r   <= scl1;
      color2_r <= pal_color;
    end
    if (s3_go && v2_r) begin
      bx3_r    <= bx2;
      ex3_r    <= ex2;
      by3_r    <= by2;
      ey3_r    <= ey2;
      color3_r <= color2_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sib_expand.sv =====
// write expander: walks a span row by row and registers one write beat a cycle while the output is not stalled
`default_nettype none

module sib_expand (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [10:0]        canvas_width,
  input  wire logic               span_valid,
  output      logic               span_ready,
  input  wire sib_pkg::sib_span_t span,
  sib_out_if.source               out_ch
);

  import sib_pkg::*;

  logic        busy_r, busy_nxt;
  logic [9:0]  cur_x_r, cur_y_r, x_lo_r, x_hi_r, y_hi_r;
  logic [7:0]  color_r;

  logic        out_valid_r, out_valid_nxt;
  logic [9:0]  ox_r, oy_r;
  logic [19:0] oaddr_r;
  logic [7:0]  ocolor_r;
  logic        olast_r;

  logic        out_free, emit, last_now, load;
  logic [10:0] stride;
  logic [20:0] addr_full;

  assign out_free   = !out_valid_r | out_ch.ready;
  assign emit       = busy_r & out_free;
  assign last_now   = (cur_x_r == x_hi_r) && (cur_y_r == y_hi_r);
  assign span_ready = !busy_r | (emit & last_now);
  assign load       = span_valid & span_ready;

  assign stride    = sat_canvas(canvas_width);
  assign addr_full = 21'(cur_y_r) * 21'(stride) + 21'(cur_x_r);

  always_comb begin
    busy_nxt = busy_r;
    if (load) begin
      busy_nxt = 1'b1;
    end else if (emit && last_now) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_x_r <= span.x_lo;
      cur_y_r <= span.y_lo;
      x_lo_r  <= span.x_lo;
      x_hi_r  <= span.x_hi;
      y_hi_r  <= span.y_hi;
      color_r <= span.color;
    end else if (emit && !last_now) begin
      if (cur_x_r == x_hi_r) begin
        cur_x_r <= x_lo_r;
        cur_y_r <= cur_y_r + 10'd1;
      end else begin
        cur_x_r <= cur_x_r + 10'd1;
      end
    end
    if (emit) begin
      ox_r     <= cur_x_r;
      oy_r     <= cur_y_r;
      oaddr_r  <= addr_full[19:0];
      ocolor_r <= color_r;
      olast_r  <= last_now;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_x       = ox_r;
  assign out_ch.pixel_y       = oy_r;
  assign out_ch.write_address = oaddr_r;
  assign out_ch.color         = ocolor_r;
  assign out_ch.last_write    = olast_r;

endmodule

`default_nettype wire

// ===== rtl/core/scaled_index_image_blitter.sv =====
// top level of the scaled index image blitter
// Blits one palette-index source pixel per input beat: the pixel is dropped when it
// lies outside the image, equals the key, is negative or its palette entry is hidden;
// otherwise its flipped cell is magnified by the clamped scale, offset by the origin,
// clipped to the clip rectangle and canvas, and each surviving pixel leaves as one
// write beat, row by row, with last_write on the final one. An operation of one loads
// a palette color and hidden flag and writes nothing. The front pipeline takes a new
// beat every cycle unless a later stage stalls; the expander emits one write per cycle
// while the output is ready, so a blit with many writes holds the input back; a beat
// that writes nothing (load, dropped or fully clipped) never reaches the expander. The
// first write passes the front stage, expander span and output registers. The palette
// resets through per-entry valid bits, so no clearing pass follows reset.
`default_nettype none

module scaled_index_image_blitter #(
  parameter int PALETTE_ENTRIES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [sib_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sib_pkg::CFG_DATA_W-1:0]    cfg_data,
  sib_in_if.sink                                 in_ch,
  sib_out_if.source                              out_ch
);

  import sib_pkg::*;

  sib_cfg_t  cfg_r;
  logic      span_valid, span_ready;
  sib_span_t span;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= 13'sd0;
      cfg_r.origin_y      <= 13'sd0;
      cfg_r.clip_left     <= 11'd0;
      cfg_r.clip_top      <= 11'd0;
      cfg_r.clip_right    <= 11'd1024;
      cfg_r.clip_bottom   <= 11'd1024;
      cfg_r.canvas_width  <= 11'd1024;
      cfg_r.canvas_height <= 11'd1024;
    end else if (cfg_we) begin
      unique case (sib_cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X:      cfg_r.origin_x      <= cfg_data;
        CFG_ORIGIN_Y:      cfg_r.origin_y      <= cfg_data;
        CFG_CLIP_LEFT:     cfg_r.clip_left     <= cfg_data[10:0];
        CFG_CLIP_TOP:      cfg_r.clip_top      <= cfg_data[10:0];
        CFG_CLIP_RIGHT:    cfg_r.clip_right    <= cfg_data[10:0];
        CFG_CLIP_BOTTOM:   cfg_r.clip_bottom   <= cfg_data[10:0];
        CFG_CANVAS_WIDTH:  cfg_r.canvas_width  <= cfg_data[10:0];
        CFG_CANVAS_HEIGHT: cfg_r.canvas_height <= cfg_data[10:0];
      endcase
    end
  end

  sib_geom #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .span_valid (span_valid),
    .span_ready (span_ready),
    .span       (span)
  );

  sib_expand u_expand (
    .clk          (clk),
    .rst_n        (rst_n),
    .canvas_width (cfg_r.canvas_width),
    .span_valid   (span_valid),
    .span_ready   (span_ready),
    .span         (span),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

// ===== verif/tb_scaled_index_image_blitter.sv =====
// self-checking testbench of the scaled index image blitter: directed rows, then random traffic
`default_nettype none

module tb_scaled_index_image_blitter;
  timeunit 1ns;
  timeprecision 1ps;

  import sib_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    sib_op_t    op;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] pix;
    logic [8:0] iw;
    logic [8:0] ih;
    logic [1:0] flip;
    logic [3:0] scale;
    logic [7:0] key;
    logic [7:0] mcolor;
    logic       hide;
  } px_beat_t;

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [19:0] addr;
    logic [7:0]  color;
    logic        last;
  } fb_write_t;

  // typed rows carry their own expectation: none, or one write
  typedef struct packed {
    px_beat_t  beat;
    logic      typed;
    logic      one;
    fb_write_t w;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sib_in_if  in_ch ();
  sib_out_if out_ch ();

  scaled_index_image_blitter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor copy of registers and palette
  int org_x = 0;
  int org_y = 0;
  int clip_l = 0;
  int clip_t = 0;
  int clip_r = 1024;
  int clip_b = 1024;
  int canv_w = 1024;
  int canv_h = 1024;
  logic [7:0] lut_color [64];
  logic       lut_hide  [64];

  fb_write_t fb_expect [$];
  fb_write_t want;
  dir_row_t  dir_tab [$];
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 28;
  int rx_idle_pct = 52;

  always #5 clk = ~clk;

  function automatic void predict_writes(input px_beat_t b);
    int e, s, dx, dy, x, y, cw, chh, n, bx, by;
    e = int'(b.pix[5:0]);
    n = 0;
    if (b.op == OP_LOAD) begin
      lut_color[e] = b.mcolor;
      lut_hide[e] = b.hide;
      return;
    end
    if (b.col >= b.iw || b.row >= b.ih) return;
    if (b.pix == b.key || b.pix[7] || lut_hide[e]) return;
    s = int'(b.scale);
    if (s < 1) s = 1;
    if (s > int'(MAX_SCALE)) s = int'(MAX_SCALE);
    dx = b.flip[0] ? int'(b.iw) - 1 - int'(b.col) : int'(b.col);
    dy = b.flip[1] ? int'(b.ih) - 1 - int'(b.row) : int'(b.row);
    cw = (canv_w > int'(CANVAS_MAX)) ? int'(CANVAS_MAX) : canv_w;
    chh = (canv_h > int'(CANVAS_MAX)) ? int'(CANVAS_MAX) : canv_h;
    for (by = 0; by < s; by++) begin
      for (bx = 0; bx < s; bx++) begin
        x = org_x + dx * s + bx;
        y = org_y + dy * s + by;
        if (x < clip_l || y < clip_t || x >= clip_r || y >= clip_b) continue;
        if (x < 0 || y < 0 || x >= cw || y >= chh) continue;
        fb_expect.push_back('{x: x[9:0], y: y[9:0], addr: 20'(y * cw + x),
                              color: lut_color[e], last: 1'b0});
        n++;
      end
    end
    if (n > 0) fb_expect[fb_expect.size() - 1].last = 1'b1;
  endfunction

  function automatic px_beat_t rand_any();
    px_beat_t b;
    b.op     = sib_op_t'(1'($urandom));
    b.col    = 8'($urandom);
    b.row    = 8'($urandom);
    b.pix    = 8'($urandom);
    b.iw     = 9'($urandom_range(1, 256));
    b.ih     = 9'($urandom_range(1, 256));
    b.flip   = 2'($urandom);
    b.scale  = 4'($urandom);
    b.key    = 8'($urandom);
    b.mcolor = 8'($urandom);
    b.hide   = 1'($urandom);
    return b;
  endfunction

  function automatic px_beat_t blit(int col, int row, int pix, int iw, int ih,
                                    int flip, int scale, int key);
    px_beat_t b;
    b = rand_any();
    b.op    = OP_BLIT;
    b.col   = 8'(col);
    b.row   = 8'(row);
    b.pix   = 8'(pix);
    b.iw    = 9'(iw);
    b.ih    = 9'(ih);
    b.flip  = 2'(flip);
    b.scale = 4'(scale);
    b.key   = 8'(key);
    return b;
  endfunction

  function automatic px_beat_t load(int entry, int color, logic hide);
    px_beat_t b;
    b = rand_any();
    b.op     = OP_LOAD;
    b.pix    = 8'(entry);
    b.mcolor = 8'(color);
    b.hide   = hide;
    return b;
  endfunction

  function automatic fb_write_t wr(int x, int y, int addr, int color);
    return '{x: 10'(x), y: 10'(y), addr: 20'(addr), color: 8'(color), last: 1'b1};
  endfunction

  // mostly well-formed blits that land, some palette loads, the rest noise
  function automatic px_beat_t rand_beat();
    px_beat_t b;
    int r;
    r = $urandom_range(0, 99);
    b = rand_any();
    if (r < 12) begin
      b.op = OP_LOAD;
      b.hide = ($urandom_range(0, 3) == 0);
    end else if (r < 82) begin
      b.op = OP_BLIT;
      b.iw = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(1, 256)) : 9'($urandom_range(1, 40));
      b.ih = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(1, 256)) : 9'($urandom_range(1, 40));
      b.col = 8'($urandom_range(0, int'(b.iw) - 1));
      b.row = 8'($urandom_range(0, int'(b.ih) - 1));
      b.pix = 8'($urandom_range(0, 127));
      if (b.key == b.pix) b.key = ~b.pix;
      b.scale = ($urandom_range(0, 6) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4));
    end
    return b;
  endfunction

  function automatic void chk(string name, logic [19:0] exp_v, logic [19:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  task automatic drive_beat(input px_beat_t b);
    in_ch.operation    <= b.op;
    in_ch.src_col      <= b.col;
    in_ch.src_row      <= b.row;
    in_ch.pixel_index  <= b.pix;
    in_ch.image_width  <= b.iw;
    in_ch.image_height <= b.ih;
    in_ch.flip_mode    <= b.flip;
    in_ch.scale_factor <= b.scale;
    in_ch.key_index    <= b.key;
    in_ch.map_color    <= b.mcolor;
    in_ch.hide_flag    <= b.hide;
  endtask

  // called and returns at a falling edge
  task automatic send_beat(input px_beat_t b, input logic typed, input logic one,
                           input fb_write_t w);
    int base;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    drive_beat(b);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    base = fb_expect.size();
    predict_writes(b);
    if (typed) begin
      while (fb_expect.size() > base) void'(fb_expect.pop_back());
      if (one) fb_expect.push_back(w);
    end
  endtask

  task automatic send_random(input int n);
    repeat (n) send_beat(rand_beat(), 1'b0, 1'b0, '0);
  endtask

  task automatic write_reg(input sib_cfg_idx_t idx, input logic [12:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ORIGIN_X:      org_x = int'($signed(val));
      CFG_ORIGIN_Y:      org_y = int'($signed(val));
      CFG_CLIP_LEFT:     clip_l = int'(val[10:0]);
      CFG_CLIP_TOP:      clip_t = int'(val[10:0]);
      CFG_CLIP_RIGHT:    clip_r = int'(val[10:0]);
      CFG_CLIP_BOTTOM:   clip_b = int'(val[10:0]);
      CFG_CANVAS_WIDTH:  canv_w = int'(val[10:0]);
      CFG_CANVAS_HEIGHT: canv_h = int'(val[10:0]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(input int ox, input int oy, input int cl, input int ct,
                               input int cr, input int cb, input int cw, input int chh);
    write_reg(CFG_ORIGIN_X, 13'(ox));
    write_reg(CFG_ORIGIN_Y, 13'(oy));
    write_reg(CFG_CLIP_LEFT, 13'(cl));
    write_reg(CFG_CLIP_TOP, 13'(ct));
    write_reg(CFG_CLIP_RIGHT, 13'(cr));
    write_reg(CFG_CLIP_BOTTOM, 13'(cb));
    write_reg(CFG_CANVAS_WIDTH, 13'(cw));
    write_reg(CFG_CANVAS_HEIGHT, 13'(chh));
    cfg_we <= 1'b0;
  endtask

  // beats that write nothing may still be in flight when the queue runs dry
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (fb_expect.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (fb_expect.size() == 0) begin
        $display("%0t: write beat with none expected, expected none actual x=%0d y=%0d",
                 $time, out_ch.pixel_x, out_ch.pixel_y);
        fail_cnt++;
      end else begin
        want = fb_expect.pop_front();
        chk("pixel_x", 20'(want.x), 20'(out_ch.pixel_x));
        chk("pixel_y", 20'(want.y), 20'(out_ch.pixel_y));
        chk("write_address", want.addr, out_ch.write_address);
        chk("color", 20'(want.color), 20'(out_ch.color));
        chk("last_write", 20'(want.last), 20'(out_ch.last_write));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_scaled_index_image_blitter failed");
      $finish;
    end
  end

  initial begin
    int i, l, t;
    for (i = 0; i < 64; i++) begin
      lut_color[i] = 8'(i);
      lut_hide[i] = 1'b0;
    end
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    drive_beat('0);

    // col, row, pixel, width, height, flip, scale, key
    dir_tab.push_back('{blit(0, 0, 5, 1, 1, 0, 1, -1), 1'b1, 1'b1, wr(0, 0, 0, 5)});
    // scale zero acts as one
    dir_tab.push_back('{blit(3, 2, 7, 8, 8, 0, 0, 0), 1'b1, 1'b1, wr(3, 2, 2051, 7)});
    dir_tab.push_back('{blit(1, 1, 9, 4, 4, 0, 1, 9), 1'b1, 1'b0, '0});
    dir_tab.push_back('{blit(0, 0, -128, 4, 4, 0, 1, 0), 1'b1, 1'b0, '0});
    // outside the source image
    dir_tab.push_back('{blit(8, 0, 3, 8, 8, 0, 1, 0), 1'b1, 1'b0, '0});
    dir_tab.push_back('{blit(0, 255, 3, 256, 255, 0, 1, 0), 1'b1, 1'b0, '0});
    dir_tab.push_back('{blit(255, 255, 127, 256, 256, 0, 1, -128), 1'b1, 1'b1,
                        wr(255, 255, 261375, 63)});
    dir_tab.push_back('{blit(0, 0, 1, 256, 256, 3, 1, 0), 1'b1, 1'b1,
                        wr(255, 255, 261375, 1)});
    dir_tab.push_back('{blit(2, 1, 10, 6, 4, 1, 2, 0), 1'b0, 1'b0, '0});
    dir_tab.push_back('{blit(2, 1, 11, 6, 4, 2, 3, 0), 1'b0, 1'b0, '0});
    dir_tab.push_back('{blit(4, 5, 12, 16, 16, 0, 8, 0), 1'b0, 1'b0, '0});
    // scale above the maximum saturates
    dir_tab.push_back('{blit(1, 1, 13, 16, 16, 3, 15, 0), 1'b0, 1'b0, '0});
    // cell lands past the canvas, every write clipped
    dir_tab.push_back('{blit(255, 0, 14, 256, 1, 0, 8, 0), 1'b1, 1'b0, '0});
    dir_tab.push_back('{load(5, 200, 1'b0), 1'b1, 1'b0, '0});
    dir_tab.push_back('{blit(6, 6, 5, 8, 8, 0, 1, 0), 1'b0, 1'b0, '0});
    // entry -1 wraps to the top palette entry
    dir_tab.push_back('{load(-1, 8'hAA, 1'b1), 1'b1, 1'b0, '0});
    dir_tab.push_back('{blit(0, 0, 63, 1, 1, 0, 1, 0), 1'b1, 1'b0, '0});
    dir_tab.push_back('{blit(0, 0, 127, 1, 1, 0, 1, 0), 1'b1, 1'b0, '0});
    dir_tab.push_back('{load(63, 255, 1'b0), 1'b1, 1'b0, '0});
    dir_tab.push_back('{blit(1, 1, 127, 2, 2, 0, 1, -128), 1'b0, 1'b0, '0});
    dir_tab.push_back('{load(0, 0, 1'b0), 1'b1, 1'b0, '0});
    dir_tab.push_back('{blit(0, 0, 0, 1, 1, 0, 1, 1), 1'b0, 1'b0, '0});
    dir_tab.push_back('{blit(3, 3, 127, 8, 8, 0, 1, 127), 1'b1, 1'b0, '0});

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[k]) send_beat(dir_tab[k].beat, dir_tab[k].typed, dir_tab[k].one,
                                   dir_tab[k].w);
    settle();
    apply_setting($urandom_range(0, 80) - 40, $urandom_range(0, 80) - 40,
                  0, 0, 1024, 1024, 1024, 1024);
    send_random(70);
    settle();
    // origin extremes push everything off the canvas
    apply_setting(-4096, 4095, 0, 0, 1024, 1024, 1024, 1024);
    send_random(15);

    settle();
    tx_idle_pct = 52;
    rx_idle_pct = 28;
    // oversized canvas saturates, clipping at the right and bottom edges
    apply_setting(900, 950, 0, 0, 2047, 2047, 2047, 2047);
    send_random(50);
    settle();
    l = $urandom_range(0, 100);
    t = $urandom_range(0, 100);
    apply_setting($urandom_range(0, 80) - 20, $urandom_range(0, 80) - 20, l, t,
                  l + $urandom_range(1, 400), t + $urandom_range(1, 400),
                  $urandom_range(1, 300), $urandom_range(1, 300));
    send_random(60);
    settle();
    // zero-width canvas and inverted clip rectangle
    apply_setting(4095, -4096, 500, 0, 100, 1024, 0, 1);
    send_random(15);

    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_setting($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100,
                  $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047));
    send_random(30);
    settle();
    apply_setting(0, 0, 0, 0, 1, 1, 1, 1);
    send_random(20);
    settle();
    apply_setting(0, 0, 0, 0, 1024, 1024, 1024, 1024);
    send_random(60);
    settle();

    if (fail_cnt == 0) begin
      $display("tb_scaled_index_image_blitter passed");
    end else begin
      $display("tb_scaled_index_image_blitter failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
